// ----- hw/rtl/sli_pkg.sv -----
`default_nettype none

package sli_pkg;

    // Request operation codes
    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Broadcast from the control to every cell of the row
    typedef struct packed {
        logic                      ins_en;
        logic                      rem_en;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/sli_if.sv -----
`default_nettype none

// Request channel: operation and value
interface sli_req_if;
    logic               valid;
    logic               ready;
    logic [0:0]         cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Response channel: status and entry count
interface sli_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sli_cell.sv -----
`default_nettype none

// One slot of the sorted row. Compares its entry with the broadcast value and
// takes the new value, its left neighbour's entry or its right neighbour's
// entry, depending on where the insert point or the removed entry lies.
module sli_cell (
    input  wire                            i_clk,
    input  wire sli_pkg::t_cell_ctl        i_ctl,
    input  wire                            i_occ,
    input  wire                            i_left_lt,
    input  wire signed [sli_pkg::VALUE_W-1:0] i_left_entry,
    input  wire signed [sli_pkg::VALUE_W-1:0] i_right_entry,
    output logic                           o_lt,
    output logic                           o_hit,
    output logic signed [sli_pkg::VALUE_W-1:0] o_entry
);
    import sli_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    // Occupied and strictly below the value: stays put
    assign o_lt  = i_occ && (r_entry < i_ctl.value);
    // First entry not below the value, and equal to it
    assign o_hit = i_occ && (r_entry == i_ctl.value) && i_left_lt;
    assign o_entry = r_entry;

    // Shift right on insert, left on remove, at and past the point
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en && !o_lt) begin
            n_entry = i_left_lt ? i_ctl.value : i_left_entry;
        end else if (i_ctl.rem_en && !o_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_list_insert_remove.sv -----
`default_nettype none

// Channel  | Dir | Fields                        | Notes
// i_req    | in  | cmd[0:0], value[31:0] signed  | 0 insert in order, 1 remove first equal
// o_rsp    | out | status[1:0], entry_count[4:0] | one response per request
//
// One request per clock unless the response stalls: every cell compares and
// shifts in the same cycle, the response appears in the output register on the next cycle.
// The compare in each cell plus the OR over the hit flags sets the path.
// Reset clears the entry count and the response valid; entry contents are
// left as they are. A stalled response holds the request side only while the
// output register is full and not taken.
module sorted_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    sli_req_if.sink   i_req,
    sli_rsp_if.source o_rsp
);
    import sli_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [COUNT_W-1:0]        r_entry_count;
    logic [1:0]                n_status;
    logic [CNT_W+COUNT_W-1:0]  count_ext;

    logic                      accept;
    logic                      full;
    logic                      found;
    t_cell_ctl                 ctl;

    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       hit;
    logic [CAPACITY-1:0]       occ;
    logic signed [VALUE_W-1:0] entry [CAPACITY];

    // Handshake: take a request whenever the output slot is free or draining
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign found = |hit;

    // Control broadcast to the row
    always_comb begin
        ctl.value  = i_req.value;
        ctl.ins_en = accept && (i_req.cmd == CMD_INSERT) && !full;
        ctl.rem_en = accept && (i_req.cmd == CMD_REMOVE) && found;
    end

    // Row of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                      left_lt;
        logic signed [VALUE_W-1:0] left_entry;
        logic signed [VALUE_W-1:0] right_entry;

        assign occ[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = entry[gi];
        end else begin : g_mid
            assign left_lt    = lt[gi-1];
            assign left_entry = entry[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_entry = entry[gi];
        end else begin : g_body
            assign right_entry = entry[gi+1];
        end

        sli_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occ         (occ[gi]),
            .i_left_lt     (left_lt),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_lt          (lt[gi]),
            .o_hit         (hit[gi]),
            .o_entry       (entry[gi])
        );
    end

    // Status and next count
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (i_req.cmd == CMD_INSERT) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (found) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                n_status = ST_MISS;
            end
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status      <= n_status;
            r_entry_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_entry_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_rsp.valid)
        else $error("no response after request");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (i_req.cmd == CMD_INSERT))
        |=> (o_rsp.status == ST_FULL) && $stable(r_count))
        else $error("insert into full store not refused");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("more than one first-equal cell");
`endif

endmodule

`default_nettype wire
